// ===== design/tcp_bandwidth_rtt_estimator_defines.svh =====
// Assertion macros shared by the bandwidth and RTT estimator.
`ifndef TCP_BANDWIDTH_RTT_ESTIMATOR_DEFINES_SVH
`define TCP_BANDWIDTH_RTT_ESTIMATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBRE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("estimator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TBRE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("estimator assertion failed");

`endif

// ===== design/tbre_pkg.sv =====
// Types and constants shared by the bandwidth and RTT estimator modules.
package tbre_pkg;

  // Event codes carried on the input kind field.
  localparam logic [2:0] EV_START = 3'd0;
  localparam logic [2:0] EV_RTT   = 3'd1;
  localparam logic [2:0] EV_FAST  = 3'd2;
  localparam logic [2:0] EV_SLOW  = 3'd3;
  localparam logic [2:0] EV_LOSS  = 3'd4;
  localparam logic [2:0] EV_CWR   = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MSS   = 2'd0;
  localparam logic [1:0] CFG_FLOOR = 2'd1;
  localparam logic [1:0] CFG_INIT  = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] MSS_RESET   = 16'd1460;
  localparam logic [15:0] FLOOR_RESET = 16'd50;
  localparam logic [31:0] INIT_RESET  = 32'd20000;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Request to the shared divider: the remainder must start below the divisor.
  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // Status and result of the shared divider.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/tbre_div.sv =====
// Shared iterative restoring divider, two quotient bits per cycle.
module tbre_div import tbre_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int Steps = 2;
  localparam int Iter  = 32 / Steps;
  localparam int CntW  = $clog2(Iter);

  logic [31:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [31:0]     den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  // Step logic: shift one dividend bit into the remainder and try a subtract.
  always_comb begin
    logic [31:0] r;
    logic [31:0] qv;
    logic [32:0] t;
    r  = rem_q;
    qv = quo_q;
    t  = '0;
    for (int k = 0; k < Steps; k++) begin
      t  = {r, qv[31]};
      qv = {qv[30:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        r     = 32'(t - {1'b0, den_q});
        qv[0] = 1'b1;
      end else begin
        r = t[31:0];
      end
    end

    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.rem_init;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = r;
      quo_d = qv;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Iter - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath registers load on start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== design/tcp_bandwidth_rtt_estimator.sv =====
// Top level of the TCP bandwidth and RTT estimator: sequencer, state and ports.
//
// Usage: one event enters on the s_axis channel (kind in tuser, timestamp,
// acked sequence and RTT sample in tdata) and exactly one result leaves on
// the m_axis channel: window limit, smoothed bandwidth, minimum RTT, windowed
// delay minimum and maximum, and the loss delay average.
// The block takes one event at a time. The shared divider runs once for the
// bandwidth rate when an ack closes the sampling window and once for the window
// limit, which is skipped when the limit saturates. The result is held in an
// output register, so the sequencer finishes the next event while a result
// waits; it only waits at its final step when the receiver is still stalled
// on the previous result.
// Reset loads the configuration defaults and the state of a fresh connection;
// no clearing pass is needed. Configuration writes are always taken and must
// only be issued while the block is idle.
`include "tcp_bandwidth_rtt_estimator_defines.svh"

module tcp_bandwidth_rtt_estimator import tbre_pkg::*; #(
  parameter int SEQ_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // Event input.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // now_tick, acked_seq, rtt_sample, zero pad
  input  logic [2:0]   s_axis_tuser,  // req_type
  // Result output.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata   // window_limit, bw_estimate, min_rtt,
                                      // window_delay_min, window_delay_max,
                                      // loss_delay_avg
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_RATE = 4'd2;
  localparam logic [3:0] S_FILT = 4'd3;
  localparam logic [3:0] S_CRED = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_LCHK = 4'd7;
  localparam logic [3:0] S_LIM  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  // One-pole low-pass filter: (7a + b) / 8 at full width.
  function automatic logic [31:0] lowpass(input logic [31:0] a, input logic [31:0] b);
    logic [34:0] s;
    s = {a, 3'b000} - {3'b000, a} + {3'b000, b};
    return s[34:3];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ALL_ONES : s[31:0];
  endfunction

  logic [3:0]          state_q, state_d;
  logic [2:0]          ev_q, ev_d;
  logic [31:0]         now_q, now_d;
  logic [31:0]         seq_q, seq_d;
  logic [30:0]         sample_q, sample_d;
  logic [15:0]         mss_q, mss_d;
  logic [15:0]         floor_q, floor_d;
  logic [31:0]         init_q, init_d;
  logic [31:0]         raw_q, raw_d;
  logic [31:0]         smooth_q, smooth_d;
  logic [31:0]         wstart_q, wstart_d;
  logic [31:0]         wbytes_q, wbytes_d;
  logic [SEQ_BITS-1:0] last_q, last_d;
  logic [31:0]         dup_q, dup_d;
  logic [31:0]         latest_q, latest_d;
  logic [31:0]         lowest_q, lowest_d;
  logic                first_q, first_d;
  logic                rearm_q, rearm_d;
  logic [31:0]         dlow_q, dlow_d;
  logic [31:0]         dhigh_q, dhigh_d;
  logic [31:0]         loss_q, loss_d;
  logic [31:0]         got_q, got_d;
  logic [63:0]         prod_q, prod_d;
  logic [31:0]         limit_q, limit_d;
  logic                out_valid_q, out_valid_d;
  logic [191:0]        out_data_q, out_data_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                in_fire;
  logic [31:0]         elapsed;
  logic [31:0]         span;
  logic                win_close;
  logic [SEQ_BITS-1:0] seq_diff;
  logic [31:0]         diff32;
  logic [33:0]         loss_sum;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Window timing and sequence distance.
  assign elapsed   = now_q - wstart_q;
  assign span      = (latest_q > {16'b0, floor_q}) ? latest_q : {16'b0, floor_q};
  assign win_close = (latest_q != '0) && (elapsed > span) && (elapsed != '0);
  assign seq_diff  = seq_q[SEQ_BITS-1:0] - last_q;
  assign diff32    = 32'(seq_diff);

  // Loss delay average, weighted three quarters old, one quarter new.
  always_comb begin
    if (loss_q > 32'd1) begin
      loss_sum = {2'b00, loss_q} - {4'b0000, loss_q[31:2]} + {2'b00, latest_q};
    end else begin
      loss_sum = {latest_q, 2'b00};
    end
  end

  tbre_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer and state update.
  always_comb begin
    logic [31:0] lo_n;
    logic [31:0] hi_n;
    state_d     = state_q;
    ev_d        = ev_q;
    now_d       = now_q;
    seq_d       = seq_q;
    sample_d    = sample_q;
    mss_d       = mss_q;
    floor_d     = floor_q;
    init_d      = init_q;
    raw_d       = raw_q;
    smooth_d    = smooth_q;
    wstart_d    = wstart_q;
    wbytes_d    = wbytes_q;
    last_d      = last_q;
    dup_d       = dup_q;
    latest_d    = latest_q;
    lowest_d    = lowest_q;
    first_d     = first_q;
    rearm_d     = rearm_q;
    dlow_d      = dlow_q;
    dhigh_d     = dhigh_q;
    loss_d      = loss_q;
    got_d       = got_q;
    prod_d      = prod_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    div_req     = '0;
    lo_n        = dlow_q;
    hi_n        = dhigh_q;

    // Configuration writes.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MSS:   mss_d   = cfg_data_i[15:0];
        CFG_FLOOR: floor_d = cfg_data_i[15:0];
        CFG_INIT:  init_d  = cfg_data_i;
        default:   ;
      endcase
    end

    // The result register empties when the receiver takes it.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ev_d     = s_axis_tuser;
          now_d    = s_axis_tdata[31:0];
          seq_d    = s_axis_tdata[63:32];
          sample_d = s_axis_tdata[94:64];
          state_d  = S_EXEC;
        end
      end

      // Decode the event; acks may close the sampling window.
      S_EXEC: begin
        state_d = S_MUL;
        case (ev_q)
          EV_START: begin
            raw_d    = '0;
            smooth_d = '0;
            wstart_d = now_q;
            wbytes_d = '0;
            last_d   = seq_q[SEQ_BITS-1:0];
            dup_d    = '0;
            latest_d = init_q;
            lowest_d = init_q;
            first_d  = 1'b1;
            rearm_d  = 1'b1;
            dlow_d   = '0;
            dhigh_d  = '0;
            loss_d   = 32'd1;
          end
          EV_RTT: begin
            if (sample_q != '0) begin
              latest_d = {1'b0, sample_q};
            end
          end
          EV_FAST, EV_SLOW: begin
            if (first_q) begin
              last_d  = seq_q[SEQ_BITS-1:0];
              first_d = 1'b0;
            end
            if (win_close) begin
              div_req.start    = 1'b1;
              div_req.rem_init = '0;
              div_req.dividend = wbytes_q;
              div_req.divisor  = elapsed;
              wbytes_d         = '0;
              wstart_d         = now_q;
              state_d          = S_RATE;
            end else begin
              state_d = S_CRED;
            end
          end
          EV_LOSS: begin
            loss_d  = (loss_sum[33:32] != 2'b00) ? ALL_ONES : loss_sum[31:0];
            rearm_d = 1'b1;
          end
          default: ;
        endcase
      end

      // Window rate ready: the first sample loads both filters.
      S_RATE: begin
        if (div_rsp.done) begin
          if (raw_q == '0 && smooth_q == '0) begin
            raw_d    = div_rsp.quotient;
            smooth_d = div_rsp.quotient;
            state_d  = S_CRED;
          end else begin
            raw_d   = lowpass(raw_q, div_rsp.quotient);
            state_d = S_FILT;
          end
        end
      end

      S_FILT: begin
        smooth_d = lowpass(smooth_q, raw_q);
        state_d  = S_CRED;
      end

      // Bytes credited by this ack, with duplicate and delayed ack accounting.
      S_CRED: begin
        if (ev_q == EV_SLOW) begin
          if (diff32 == '0) begin
            dup_d = sat_add(dup_q, {16'b0, mss_q});
            got_d = {16'b0, mss_q};
          end else if (diff32 > {16'b0, mss_q}) begin
            if (dup_q >= diff32) begin
              dup_d = dup_q - diff32;
              got_d = {16'b0, mss_q};
            end else begin
              dup_d = '0;
              got_d = diff32 - dup_q;
            end
          end else begin
            got_d = diff32;
          end
        end else begin
          got_d = diff32;
        end
        last_d  = seq_q[SEQ_BITS-1:0];
        state_d = S_ACC;
      end

      // Accumulate bytes, track minimum RTT and the delay window.
      S_ACC: begin
        wbytes_d = sat_add(wbytes_q, got_q);
        if (rearm_q) begin
          lowest_d = latest_q;
          rearm_d  = 1'b0;
        end else if (latest_q < lowest_q) begin
          lowest_d = latest_q;
        end
        if (ev_q == EV_SLOW) begin
          if (dlow_q == '0 && dhigh_q == '0 && latest_q != init_q) begin
            lo_n = latest_q;
            hi_n = latest_q;
          end
          if (latest_q > hi_n) begin
            hi_n = latest_q;
          end else if (latest_q < lo_n) begin
            lo_n = latest_q;
          end
          dlow_d  = lo_n;
          dhigh_d = hi_n;
        end
        state_d = S_MUL;
      end

      S_MUL: begin
        prod_d  = 64'(smooth_q) * 64'(lowest_q);
        state_d = S_LCHK;
      end

      // A high half at or above the segment size means the quotient overflows.
      S_LCHK: begin
        if (prod_q[63:32] >= {16'b0, mss_q}) begin
          limit_d = ALL_ONES;
          state_d = S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = prod_q[63:32];
          div_req.dividend = prod_q[31:0];
          div_req.divisor  = {16'b0, mss_q};
          state_d          = S_LIM;
        end
      end

      S_LIM: begin
        if (div_rsp.done) begin
          limit_d = (div_rsp.quotient < 32'd2) ? 32'd2 : div_rsp.quotient;
          state_d = S_FIN;
        end
      end

      // Hand the result over once the output register is free.
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {loss_q, dhigh_q, dlow_q, lowest_q, smooth_q, limit_q};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control, configuration and connection state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mss_q       <= MSS_RESET;
      floor_q     <= FLOOR_RESET;
      init_q      <= INIT_RESET;
      raw_q       <= '0;
      smooth_q    <= '0;
      wstart_q    <= '0;
      wbytes_q    <= '0;
      last_q      <= '0;
      dup_q       <= '0;
      latest_q    <= INIT_RESET;
      lowest_q    <= INIT_RESET;
      first_q     <= 1'b1;
      rearm_q     <= 1'b1;
      dlow_q      <= '0;
      dhigh_q     <= '0;
      loss_q      <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mss_q       <= mss_d;
      floor_q     <= floor_d;
      init_q      <= init_d;
      raw_q       <= raw_d;
      smooth_q    <= smooth_d;
      wstart_q    <= wstart_d;
      wbytes_q    <= wbytes_d;
      last_q      <= last_d;
      dup_q       <= dup_d;
      latest_q    <= latest_d;
      lowest_q    <= lowest_d;
      first_q     <= first_d;
      rearm_q     <= rearm_d;
      dlow_q      <= dlow_d;
      dhigh_q     <= dhigh_d;
      loss_q      <= loss_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured request fields and intermediate results.
  always_ff @(posedge clk_i) begin
    ev_q       <= ev_d;
    now_q      <= now_d;
    seq_q      <= seq_d;
    sample_q   <= sample_d;
    got_q      <= got_d;
    prod_q     <= prod_d;
    limit_q    <= limit_d;
    out_data_q <= out_data_d;
  end

  // The window limit is never reported below two segments.
  `TBRE_ASSERT_IMP(a_limit_floor, m_axis_tvalid, m_axis_tdata[31:0] >= 32'd2)
  // The divider only runs while the sequencer waits for it.
  `TBRE_ASSERT_IMP(a_div_owner, div_rsp.busy, state_q == S_RATE || state_q == S_LIM)
  // An accepted request is decoded in the following cycle.
  `TBRE_ASSERT_NXT(a_decode_next, in_fire, state_q == S_EXEC)
  // After an ack has been accounted, the minimum RTT is armed no longer.
  `TBRE_ASSERT_NXT(a_rearm_done, state_q == S_ACC, !rearm_q)

endmodule

// ===== sim/tb_tcp_bandwidth_rtt_estimator.sv =====
// Self-checking testbench for the TCP bandwidth and RTT estimator.
module tb_tcp_bandwidth_rtt_estimator import tbre_pkg::*;;

  localparam int SEQ_BITS        = 32;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES    = 10000;
  localparam int TAIL_CYCLES     = 60;
  localparam int TIMEOUT_CYCLES  = 4000000;

  // Event codes that the block does not define; they must still report.
  localparam logic [2:0] EV_SPARE_LO = 3'd6;
  localparam logic [2:0] EV_SPARE_HI = 3'd7;

  // One event request.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_tick;
    logic [31:0] acked_seq;
    logic [30:0] rtt_sample;
  } est_event_t;

  // One result, laid out as on m_axis_tdata (window_limit in the lowest bits).
  typedef struct packed {
    logic [31:0] loss_delay_avg;
    logic [31:0] window_delay_max;
    logic [31:0] window_delay_min;
    logic [31:0] min_rtt;
    logic [31:0] bw_estimate;
    logic [31:0] window_limit;
  } est_result_t;

  // Directed row: an event and, where it is obvious, the result typed in.
  typedef struct {
    est_event_t  ev;
    bit          typed;
    est_result_t want;
  } stim_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [1:0]     cfg_index_i;
  logic [31:0]    cfg_data_i;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [95:0]    s_axis_tdata;   // now_tick, acked_seq, rtt_sample, zero pad
  logic [2:0]     s_axis_tuser;   // req_type
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [191:0]   m_axis_tdata;   // window_limit, bw_estimate, min_rtt,
                                  // window_delay_min, window_delay_max,
                                  // loss_delay_avg

  string       field_name [6] = '{"window_limit", "bw_estimate", "min_rtt",
                                  "window_delay_min", "window_delay_max",
                                  "loss_delay_avg"};
  est_result_t estimates_due [$];
  stim_row_t   directed_rows [$];
  int          error_count = 0;
  int          results_seen = 0;
  bit          long_hold_done = 1'b0;

  // Predictor copy of the configuration.
  logic [15:0] mss_cfg;
  logic [15:0] floor_cfg;
  logic [31:0] init_cfg;

  // Predictor copy of the connection state.
  logic [31:0] bw_raw;
  logic [31:0] bw_smooth;
  logic [31:0] win_open_tick;
  logic [31:0] win_byte_count;
  logic [31:0] prev_ack_seq;
  logic [31:0] dup_credit;
  logic [31:0] rtt_recent;
  logic [31:0] rtt_lowest;
  logic        first_ack_wait;
  logic        min_rearm;
  logic [31:0] dly_low;
  logic [31:0] dly_high;
  logic [31:0] loss_avg4;

  // Stimulus cursors for timestamps and sequence numbers.
  logic [31:0] clock_now;
  logic [31:0] seq_now;

  tcp_bandwidth_rtt_estimator #(
    .SEQ_BITS(SEQ_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ALL_ONES : s[31:0];
  endfunction

  // 7/8 low-pass step, formed at full width before the shift.
  function automatic logic [31:0] smooth7(input logic [31:0] a, input logic [31:0] b);
    logic [34:0] t;
    t = 35'(a) * 35'd7 + 35'(b);
    return t[34:3];
  endfunction

  function automatic void open_connection(input logic [31:0] now, input logic [31:0] seq);
    bw_raw         = '0;
    bw_smooth      = '0;
    win_open_tick  = now;
    win_byte_count = '0;
    prev_ack_seq   = seq;
    dup_credit     = '0;
    rtt_recent     = init_cfg;
    rtt_lowest     = init_cfg;
    first_ack_wait = 1'b1;
    min_rearm      = 1'b1;
    dly_low        = '0;
    dly_high       = '0;
    loss_avg4      = 32'd1;
  endfunction

  function automatic void reset_estimator();
    mss_cfg   = MSS_RESET;
    floor_cfg = FLOOR_RESET;
    init_cfg  = INIT_RESET;
    open_connection('0, '0);
  endfunction

  // Closes the sampling window once more than max(rtt, floor) ticks passed.
  function automatic void roll_window(input logic [31:0] now, input logic [31:0] seq);
    logic [31:0] elapsed;
    logic [31:0] span;
    logic [31:0] rate;
    elapsed = now - win_open_tick;
    span = (rtt_recent > 32'(floor_cfg)) ? rtt_recent : 32'(floor_cfg);
    if (first_ack_wait) begin
      prev_ack_seq   = seq;
      first_ack_wait = 1'b0;
    end
    if (rtt_recent != 0 && elapsed > span && elapsed != 0) begin
      rate = win_byte_count / elapsed;
      if (bw_raw == 0 && bw_smooth == 0) begin
        bw_raw    = rate;
        bw_smooth = rate;
      end else begin
        bw_raw    = smooth7(bw_raw, rate);
        bw_smooth = smooth7(bw_smooth, bw_raw);
      end
      win_byte_count = '0;
      win_open_tick  = now;
    end
  endfunction

  function automatic void follow_min_rtt();
    if (min_rearm) begin
      rtt_lowest = rtt_recent;
      min_rearm  = 1'b0;
    end else if (rtt_recent < rtt_lowest) begin
      rtt_lowest = rtt_recent;
    end
  endfunction

  // Applies one event to the predictor state and returns its result.
  function automatic est_result_t estimator_update(input est_event_t ev);
    est_result_t r;
    logic [31:0] got;
    logic [63:0] wide;
    logic [63:0] quot;
    case (ev.kind)
      EV_START: open_connection(ev.now_tick, ev.acked_seq);
      EV_RTT: begin
        if (ev.rtt_sample != 0) begin
          rtt_recent = 32'(ev.rtt_sample);
        end
      end
      EV_FAST: begin
        roll_window(ev.now_tick, ev.acked_seq);
        win_byte_count = sat_sum(win_byte_count, ev.acked_seq - prev_ack_seq);
        prev_ack_seq   = ev.acked_seq;
        follow_min_rtt();
      end
      EV_SLOW: begin
        roll_window(ev.now_tick, ev.acked_seq);
        // Duplicate acks earn one segment of credit; big jumps spend it.
        got = ev.acked_seq - prev_ack_seq;
        if (got == 0) begin
          dup_credit = sat_sum(dup_credit, 32'(mss_cfg));
          got = 32'(mss_cfg);
        end
        if (got > 32'(mss_cfg)) begin
          if (dup_credit >= got) begin
            dup_credit = dup_credit - got;
            got = 32'(mss_cfg);
          end else begin
            got = got - dup_credit;
            dup_credit = '0;
          end
        end
        prev_ack_seq   = ev.acked_seq;
        win_byte_count = sat_sum(win_byte_count, got);
        follow_min_rtt();
        // Windowed delay extremes, seeded by the first real sample.
        if (dly_low == 0 && dly_high == 0 && rtt_recent != init_cfg) begin
          dly_low  = rtt_recent;
          dly_high = rtt_recent;
        end
        if (rtt_recent > dly_high) begin
          dly_high = rtt_recent;
        end else if (rtt_recent < dly_low) begin
          dly_low = rtt_recent;
        end
      end
      EV_LOSS: begin
        if (loss_avg4 != 0 && loss_avg4 != 1) begin
          wide = 64'(loss_avg4) - 64'(loss_avg4 >> 2) + 64'(rtt_recent);
        end else begin
          wide = 64'(rtt_recent) << 2;
        end
        loss_avg4 = (wide > 64'(ALL_ONES)) ? ALL_ONES : wide[31:0];
        min_rearm = 1'b1;
      end
      default: ;
    endcase
    // Window limit: full-width product, saturated quotient, floor of two.
    wide = 64'(bw_smooth) * 64'(rtt_lowest);
    quot = (mss_cfg == 0) ? 64'(ALL_ONES) : wide / 64'(mss_cfg);
    if (quot > 64'(ALL_ONES)) begin
      quot = 64'(ALL_ONES);
    end
    r.window_limit     = (quot < 64'd2) ? 32'd2 : quot[31:0];
    r.bw_estimate      = bw_smooth;
    r.min_rtt          = rtt_lowest;
    r.window_delay_min = dly_low;
    r.window_delay_max = dly_high;
    r.loss_delay_avg   = loss_avg4;
    return r;
  endfunction

  // Result of a connection with no samples yet, at the default settings.
  function automatic est_result_t quiet_result(input logic [31:0] loss_avg);
    est_result_t r;
    r = '0;
    r.window_limit   = 32'd2;
    r.min_rtt        = INIT_RESET;
    r.loss_delay_avg = loss_avg;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] kind, input logic [31:0] now,
                                  input logic [31:0] seq, input logic [30:0] rtt,
                                  input bit typed, input est_result_t want);
    stim_row_t row;
    row.ev    = '{kind: kind, now_tick: now, acked_seq: seq, rtt_sample: rtt};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Random event: mostly well-formed ack traffic with sample, loss and noise.
  function automatic est_event_t next_random_event(input bit opening);
    est_event_t ev;
    int pick;
    pick = opening ? 0 : $urandom_range(0, 99);
    ev.rtt_sample = 31'($urandom);
    clock_now = clock_now + $urandom_range(0, 8);
    if (pick < 3) begin
      ev.kind   = EV_START;
      clock_now = $urandom;
      seq_now   = $urandom;
    end else if (pick < 23) begin
      ev.kind = EV_RTT;
      case ($urandom_range(0, 9))
        0:       ev.rtt_sample = '0;
        1:       ev.rtt_sample = 31'($urandom);
        default: ev.rtt_sample = 31'($urandom_range(1, 300));
      endcase
    end else if (pick < 80) begin
      ev.kind = (pick < 50) ? EV_FAST : EV_SLOW;
      case ($urandom_range(0, 9))
        0:       clock_now = $urandom;
        1:       clock_now = clock_now + $urandom_range(0, 70000);
        default: clock_now = clock_now + $urandom_range(0, 30);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: ;
        3:       seq_now = $urandom;
        4:       seq_now = seq_now + $urandom_range(32'(mss_cfg), 32'(mss_cfg) * 8);
        default: seq_now = seq_now + $urandom_range(1, 32'(mss_cfg));
      endcase
    end else if (pick < 88) begin
      ev.kind = EV_LOSS;
    end else if (pick < 94) begin
      ev.kind = EV_CWR;
    end else begin
      ev.kind = $urandom_range(0, 1) ? EV_SPARE_LO : EV_SPARE_HI;
    end
    ev.now_tick  = clock_now;
    ev.acked_seq = seq_now;
    return ev;
  endfunction

  // Offers one request and records its expected result once it is taken.
  task automatic offer_event(input est_event_t ev, input bit typed, input est_result_t want);
    est_result_t predicted;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.kind;
    s_axis_tdata  <= {1'b0, ev.rtt_sample, ev.acked_seq, ev.now_tick};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = estimator_update(ev);
    estimates_due.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_MSS:   mss_cfg   = value[15:0];
      CFG_FLOOR: floor_cfg = value[15:0];
      CFG_INIT:  init_cfg  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    int waited;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (waited = 0; waited < DRAIN_CYCLES && estimates_due.size() != 0; waited++) begin
      @(posedge clk_i);
    end
    if (estimates_due.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", estimates_due.size()));
      estimates_due.delete();
    end
  endtask

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    est_result_t got;
    est_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (estimates_due.size() == 0) begin
        flag_error($sformatf("unexpected result %h", got));
      end else begin
        want = estimates_due.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
            flag_error($sformatf("result %0d %s: got %h, expected %h", results_seen,
                                 field_name[f], got[f*32 +: 32], want[f*32 +: 32]));
          end
        end
      end
      results_seen++;
    end
  end

  // Receiver: stretches of steady, patchy and stalled ready, and long hold-offs.
  initial begin
    int span;
    int mode;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 63);
      span = $urandom_range(1, 40);
      // One long hold-off once traffic is flowing, so the input backs up.
      if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        mode = 63;
        span = 400;
      end else if (mode == 63) begin
        span = $urandom_range(100, 300);
      end
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (mode < 24) begin
          m_axis_tready <= 1'b1;
        end else if (mode < 52) begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end else begin
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("tb_tcp_bandwidth_rtt_estimator: errors");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases over several settings.
  initial begin
    est_event_t ev;
    int         burst_left;
    int         gap;
    logic [15:0] mss_v;
    logic [15:0] floor_v;
    logic [31:0] init_v;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MSS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = EV_START;
    reset_estimator();
    clock_now = '0;
    seq_now   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fresh block, quiet requests, then start and ack corner cases.
    add_row(EV_CWR,      32'd0,        32'd0,        31'd0,        1, quiet_result(32'd1));
    add_row(EV_SPARE_LO, 32'h1234_5678, 32'h9ABC_DEF0, 31'h2AAA_5555, 1, quiet_result(32'd1));
    add_row(EV_SPARE_HI, ALL_ONES,     ALL_ONES,     '1,           1, quiet_result(32'd1));
    add_row(EV_RTT,      32'd0,        32'd0,        31'd0,        1, quiet_result(32'd1));
    add_row(EV_LOSS,     32'd0,        32'd0,        31'd0,        1, quiet_result(32'd80000));
    add_row(EV_START,    32'd1000,     32'hFFFF_FFF0, 31'd0,       1, quiet_result(32'd1));
    add_row(EV_FAST,     32'd1000,     32'hFFFF_FFF0, 31'd0,       0, '0);
    add_row(EV_RTT,      32'd1000,     32'd0,        31'd1,        0, '0);
    // Duplicate ack, then a jump across the sequence wrap that spends the credit.
    add_row(EV_SLOW,     32'd1010,     32'hFFFF_FFF0, 31'd0,       0, '0);
    add_row(EV_SLOW,     32'd1020,     32'h0000_1000, 31'd0,       0, '0);
    // Two window closes: the first loads the filters, the second smooths.
    add_row(EV_FAST,     32'd1100,     32'h8000_0000, 31'd0,       0, '0);
    add_row(EV_FAST,     32'd1200,     32'h8000_0000, 31'd0,       0, '0);
    // Largest sample, loss average saturation, and a saturated window limit.
    add_row(EV_RTT,      32'd1200,     32'd0,        31'h7FFF_FFFF, 0, '0);
    add_row(EV_LOSS,     32'd1200,     32'd0,        31'd0,        0, '0);
    add_row(EV_LOSS,     32'd1200,     32'd0,        31'd0,        0, '0);
    add_row(EV_FAST,     32'd1201,     32'h8000_0000, 31'd0,       0, '0);
    // Byte count saturation while the long RTT keeps the window open.
    add_row(EV_FAST,     32'd1201,     32'h7000_0000, 31'd0,       0, '0);
    add_row(EV_FAST,     32'd1201,     32'h6000_0000, 31'd0,       0, '0);
    add_row(EV_SLOW,     32'd1202,     32'h6000_0000, 31'd0,       0, '0);
    add_row(EV_RTT,      32'd1202,     32'd0,        31'd3,        0, '0);
    add_row(EV_SLOW,     32'd1203,     32'h6000_05B4, 31'd0,       0, '0);
    // Timestamp wrap across the window.
    add_row(EV_FAST,     32'hFFFF_FFF0, 32'h6000_05B4, 31'd0,      0, '0);
    add_row(EV_FAST,     32'h0000_0040, 32'h6000_1000, 31'd0,      0, '0);
    add_row(EV_CWR,      ALL_ONES,     ALL_ONES,     '1,           0, '0);
    add_row(EV_START,    ALL_ONES,     ALL_ONES,     '1,           1, quiet_result(32'd1));

    foreach (directed_rows[i]) begin
      offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      // New settings between phases, once the block is idle.
      if (p > 0) begin
        case (p)
          1: begin
            mss_v = 16'd1; floor_v = 16'd1; init_v = 32'd1;
          end
          2: begin
            mss_v = 16'hFFFF; floor_v = 16'hFFFF; init_v = ALL_ONES;
          end
          4: begin
            mss_v = MSS_RESET; floor_v = FLOOR_RESET; init_v = INIT_RESET;
          end
          5: begin
            mss_v   = 16'($urandom_range(1, 65535));
            floor_v = 16'($urandom_range(1, 200));
            init_v  = $urandom_range(1, 1000);
          end
          default: begin
            mss_v   = 16'($urandom_range(1, 65535));
            floor_v = 16'($urandom_range(1, 65535));
            init_v  = $urandom_range(1, 32'hFFFF_FFFF);
          end
        endcase
        write_reg(CFG_MSS, {16'd0, mss_v});
        write_reg(CFG_FLOOR, {16'd0, floor_v});
        write_reg(CFG_INIT, init_v);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Sender bursts with random gaps in between.
        if (burst_left == 0) begin
          gap = $urandom_range(0, 12);
          repeat (gap) begin
            @(negedge clk_i);
            s_axis_tvalid <= 1'b0;
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        ev = next_random_event(i == 0);
        offer_event(ev, 1'b0, '0);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (estimates_due.size() != 0) begin
      flag_error($sformatf("%0d results left over", estimates_due.size()));
    end
    if (error_count == 0) begin
      $display("tb_tcp_bandwidth_rtt_estimator: clean");
    end else begin
      $display("tb_tcp_bandwidth_rtt_estimator: errors");
    end
    $finish;
  end

endmodule
